// ----- design/rics_pkg.sv -----
// Shared types, constants and helpers for the reprojection inlier scoring core.
package rics_pkg;

  localparam int MAX_POINTS_DEF    = 512;
  localparam int MIN_CONSENSUS_DEF = 4;

  localparam int POSE_WORDS = 12;
  localparam int CNT_W      = 10;
  localparam int ACC_W      = 37;   // camera coordinate, Q16.16 with headroom
  localparam int NUM_W      = 50;   // coordinate times focal length
  localparam int MAG_W      = 49;   // magnitude of NUM_W
  localparam int QUO_BITS   = 48;   // quotient bits, Q32.16
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    KIND_BEGIN = 2'd0,
    KIND_POSE  = 2'd1,
    KIND_POINT = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FOCAL_X   = 3'd0,
    CFG_FOCAL_Y   = 3'd1,
    CFG_CENTER_X  = 3'd2,
    CFG_CENTER_Y  = 3'd3,
    CFG_THRESHOLD = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_DRAIN,
    S_CHECK,
    S_PMUL,
    S_DINIT,
    S_DIV,
    S_PROJ,
    S_SQR,
    S_SCORE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic       take;       // input transaction accepted this cycle
    logic       mul_step;   // multiply one pose word by one coordinate
    logic [3:0] mul_idx;
    logic       proj_mul;
    logic       div_init;
    logic       div_step;
    logic       proj;
    logic       sqr;
    logic       score;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic behind;    // point at or behind the camera
    logic out_free;  // result register can take a new result
  } sts_t;

  // Coordinate column of a rotation word
  function automatic logic [1:0] col_of(input logic [3:0] idx);
    logic [1:0] c;
    unique case (idx)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      4'd2, 4'd5, 4'd8: c = 2'd2;
      default:          c = 2'd0;
    endcase
    return c;
  endfunction

  // Row of a rotation word
  function automatic logic [1:0] row_of(input logic [3:0] idx);
    logic [1:0] r;
    unique case (idx)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      4'd6, 4'd7, 4'd8: r = 2'd2;
      default:          r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- design/reprojection_inlier_scoring_core.sv -----
// Top level of the reprojection inlier scoring core.
// Usage:
//   Configuration: write focal_x, focal_y, center_x, center_y, error_threshold
//   at cfg_index 0..4 over the cfg_valid/cfg_ready channel while idle; writes
//   beyond index 4 are dropped. cfg_ready is always high.
//   Input channel (in_valid/in_stall): kind 0 clears the counts, kind 1 loads
//   one pose word, kind 2 scores one point. Kinds 0, 1 and 3 give no result.
//   Output channel (out_valid/out_stall): one result per scored point.
// Sequence: a point runs 9 pose multiplies, a 48-bit bit-serial division for
//   the perspective divide, both coordinates in parallel, plus setup, error and
//   score steps; points at or behind the camera skip the divide.
//   The next transaction is accepted once the result is in the output register.
// Reset: synchronous; pose words, counts and configuration clear to zero.
// Stall: a stalled result holds; a new point may run while it waits, and its
//   result is loaded only once the previous one is taken.
module reprojection_inlier_scoring_core #(
  parameter int MAX_POINTS    = rics_pkg::MAX_POINTS_DEF,
  parameter int MIN_CONSENSUS = rics_pkg::MIN_CONSENSUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rics_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rics_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        kind,
  input  logic [3:0]                        pose_index,
  input  logic signed [31:0]                pose_value,
  input  logic signed [31:0]                obj_x,
  input  logic signed [31:0]                obj_y,
  input  logic signed [31:0]                obj_z,
  input  logic signed [31:0]                img_x,
  input  logic signed [31:0]                img_y,
  input  logic                              last_point,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                proj_x,
  output logic signed [31:0]                proj_y,
  output logic                              inlier,
  output logic [rics_pkg::CNT_W-1:0]        good_count,
  output logic                              hypothesis_done,
  output logic                              better
);

  rics_pkg::cmd_t cmd;
  rics_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rics_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rics_dp #(
    .MAX_POINTS    (MAX_POINTS),
    .MIN_CONSENSUS (MIN_CONSENSUS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .pose_index      (pose_index),
    .pose_value      (pose_value),
    .obj_x           (obj_x),
    .obj_y           (obj_y),
    .obj_z           (obj_z),
    .img_x           (img_x),
    .img_y           (img_y),
    .last_point      (last_point),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .proj_x          (proj_x),
    .proj_y          (proj_y),
    .inlier          (inlier),
    .good_count      (good_count),
    .hypothesis_done (hypothesis_done),
    .better          (better)
  );

endmodule

// ----- design/rics_ctrl.sv -----
// Sequencing state machine for the reprojection inlier scoring core.
module rics_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          kind,
  output logic                in_stall,
  input  rics_pkg::sts_t      sts,
  output rics_pkg::cmd_t      cmd
);

  localparam logic [3:0] MUL_LAST = 4'd8;
  localparam logic [5:0] DIV_LAST = 6'(rics_pkg::QUO_BITS - 1);

  rics_pkg::state_t state, state_next;
  logic [3:0] mul_idx;
  logic [5:0] div_cnt;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rics_pkg::S_IDLE:
        if (in_valid && kind == rics_pkg::KIND_POINT) state_next = rics_pkg::S_MUL;
      rics_pkg::S_MUL:
        if (mul_idx == MUL_LAST) state_next = rics_pkg::S_DRAIN;
      rics_pkg::S_DRAIN: state_next = rics_pkg::S_CHECK;
      rics_pkg::S_CHECK:
        state_next = sts.behind ? rics_pkg::S_PROJ : rics_pkg::S_PMUL;
      rics_pkg::S_PMUL:  state_next = rics_pkg::S_DINIT;
      rics_pkg::S_DINIT: state_next = rics_pkg::S_DIV;
      rics_pkg::S_DIV:
        if (div_cnt == DIV_LAST) state_next = rics_pkg::S_PROJ;
      rics_pkg::S_PROJ:  state_next = rics_pkg::S_SQR;
      rics_pkg::S_SQR:   state_next = rics_pkg::S_SCORE;
      rics_pkg::S_SCORE:
        if (sts.out_free) state_next = rics_pkg::S_IDLE;
      default: state_next = rics_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.mul_idx  = mul_idx;
    in_stall     = (state != rics_pkg::S_IDLE);
    cmd.take     = (state == rics_pkg::S_IDLE) && in_valid;
    cmd.mul_step = (state == rics_pkg::S_MUL);
    cmd.proj_mul = (state == rics_pkg::S_PMUL);
    cmd.div_init = (state == rics_pkg::S_DINIT);
    cmd.div_step = (state == rics_pkg::S_DIV);
    cmd.proj     = (state == rics_pkg::S_PROJ);
    cmd.sqr      = (state == rics_pkg::S_SQR);
    cmd.score    = (state == rics_pkg::S_SCORE) && sts.out_free;
  end

  // Hold state and step counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rics_pkg::S_IDLE;
      mul_idx <= '0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      mul_idx <= (state == rics_pkg::S_MUL) ? mul_idx + 4'd1 : '0;
      div_cnt <= (state == rics_pkg::S_DIV) ? div_cnt + 6'd1 : '0;
    end
  end

endmodule

// ----- design/rics_dp.sv -----
// Datapath: pose store, transform, projection dividers, error test and counts.
module rics_dp #(
  parameter int MAX_POINTS    = rics_pkg::MAX_POINTS_DEF,
  parameter int MIN_CONSENSUS = rics_pkg::MIN_CONSENSUS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rics_pkg::cmd_t                    cmd,
  output rics_pkg::sts_t                    sts,
  input  logic                              cfg_we,
  input  logic [rics_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rics_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [1:0]                        kind,
  input  logic [3:0]                        pose_index,
  input  logic signed [31:0]                pose_value,
  input  logic signed [31:0]                obj_x,
  input  logic signed [31:0]                obj_y,
  input  logic signed [31:0]                obj_z,
  input  logic signed [31:0]                img_x,
  input  logic signed [31:0]                img_y,
  input  logic                              last_point,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [31:0]                proj_x,
  output logic signed [31:0]                proj_y,
  output logic                              inlier,
  output logic [rics_pkg::CNT_W-1:0]        good_count,
  output logic                              hypothesis_done,
  output logic                              better
);

  localparam int ACC_W = rics_pkg::ACC_W;
  localparam int NUM_W = rics_pkg::NUM_W;
  localparam int MAG_W = rics_pkg::MAG_W;
  localparam int QB    = rics_pkg::QUO_BITS;
  localparam int CNT_W = rics_pkg::CNT_W;
  localparam int CAP_I = (MAX_POINTS < 1023) ? MAX_POINTS : 1023;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(CAP_I);
  localparam logic [CNT_W-1:0] MIN_CONS  = CNT_W'(MIN_CONSENSUS);
  localparam logic signed [50:0] I32_MAX = 51'sd2147483647;
  localparam logic signed [50:0] I32_MIN = -51'sd2147483648;
  localparam logic signed [32:0] ERR_LIM = 33'sd33554432;

  // Configuration registers
  logic [11:0] focal_x, focal_y, center_x, center_y;
  logic [15:0] error_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x         <= '0;
      focal_y         <= '0;
      center_x        <= '0;
      center_y        <= '0;
      error_threshold <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rics_pkg::CFG_FOCAL_X:   focal_x         <= cfg_data[11:0];
        rics_pkg::CFG_FOCAL_Y:   focal_y         <= cfg_data[11:0];
        rics_pkg::CFG_CENTER_X:  center_x        <= cfg_data[11:0];
        rics_pkg::CFG_CENTER_Y:  center_y        <= cfg_data[11:0];
        rics_pkg::CFG_THRESHOLD: error_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pose words
  logic signed [31:0] pose [rics_pkg::POSE_WORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rics_pkg::POSE_WORDS; i++) pose[i] <= '0;
    end else if (cmd.take && kind == rics_pkg::KIND_POSE &&
                 pose_index < 4'(rics_pkg::POSE_WORDS)) begin
      pose[pose_index] <= pose_value;
    end
  end

  // Latch the point
  logic signed [31:0] pt [3];
  logic signed [31:0] ix, iy;
  logic               last_q;

  always_ff @(posedge clk) begin
    if (cmd.take && kind == rics_pkg::KIND_POINT) begin
      pt[0]  <= obj_x;
      pt[1]  <= obj_y;
      pt[2]  <= obj_z;
      ix     <= img_x;
      iy     <= img_y;
      last_q <= last_point;
    end
  end

  // Rotate and translate: one product a cycle, accumulate the next
  logic signed [63:0]      prod;
  logic [1:0]              prow;
  logic                    prod_vld;
  logic signed [ACC_W-1:0] acc [3];
  logic signed [33:0]      prod_sh;

  assign prod_sh = 34'(prod >>> 30);

  always_ff @(posedge clk) begin
    prod <= pose[cmd.mul_idx] * pt[rics_pkg::col_of(cmd.mul_idx)];
    prow <= rics_pkg::row_of(cmd.mul_idx);
    if (rst) prod_vld <= 1'b0;
    else     prod_vld <= cmd.mul_step;
    if (cmd.take && kind == rics_pkg::KIND_POINT) begin
      acc[0] <= ACC_W'(pose[9]);
      acc[1] <= ACC_W'(pose[10]);
      acc[2] <= ACC_W'(pose[11]);
    end else if (prod_vld) begin
      acc[prow] <= acc[prow] + ACC_W'(prod_sh);
    end
  end

  assign sts.behind = (acc[2] <= 0);

  // Scale by focal length
  logic signed [NUM_W-1:0] num_x, num_y;

  always_ff @(posedge clk) begin
    if (cmd.proj_mul) begin
      num_x <= acc[0] * $signed({1'b0, focal_x});
      num_y <= acc[1] * $signed({1'b0, focal_y});
    end
  end

  // Two restoring dividers, one quotient bit a cycle, shared divisor
  logic [MAG_W-1:0] a_x, a_y;
  logic [ACC_W-1:0] dvs;
  logic             neg_x, neg_y, ovf_x, ovf_y;
  logic [ACC_W-1:0] rem_x, rem_y;
  logic [QB-1:0]    nsh_x, nsh_y, q_x, q_y;
  logic [ACC_W:0]   rs_x, rs_y;

  assign a_x = MAG_W'(num_x[NUM_W-1] ? -num_x : num_x);
  assign a_y = MAG_W'(num_y[NUM_W-1] ? -num_y : num_y);
  assign dvs = ACC_W'(acc[2]);
  assign rs_x = {rem_x, nsh_x[QB-1]};
  assign rs_y = {rem_y, nsh_y[QB-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg_x <= num_x[NUM_W-1];
      neg_y <= num_y[NUM_W-1];
      ovf_x <= {20'd0, a_x} >= {dvs, 32'd0};
      ovf_y <= {20'd0, a_y} >= {dvs, 32'd0};
      rem_x <= ACC_W'(a_x[MAG_W-1:32]);
      rem_y <= ACC_W'(a_y[MAG_W-1:32]);
      nsh_x <= {a_x[31:0], 16'd0};
      nsh_y <= {a_y[31:0], 16'd0};
      q_x   <= '0;
      q_y   <= '0;
    end else if (cmd.div_step) begin
      nsh_x <= nsh_x << 1;
      nsh_y <= nsh_y << 1;
      if (rs_x >= {1'b0, dvs}) begin
        rem_x <= ACC_W'(rs_x - {1'b0, dvs});
        q_x   <= {q_x[QB-2:0], 1'b1};
      end else begin
        rem_x <= ACC_W'(rs_x);
        q_x   <= {q_x[QB-2:0], 1'b0};
      end
      if (rs_y >= {1'b0, dvs}) begin
        rem_y <= ACC_W'(rs_y - {1'b0, dvs});
        q_y   <= {q_y[QB-2:0], 1'b1};
      end else begin
        rem_y <= ACC_W'(rs_y);
        q_y   <= {q_y[QB-2:0], 1'b0};
      end
    end
  end

  // Sign, offset by the principal point, saturate
  logic [MAG_W-1:0]   mag_x, mag_y;
  logic signed [50:0] val_x, val_y, sv_x, sv_y;
  logic signed [31:0] px, py;

  assign mag_x = ovf_x ? MAG_W'(1) << QB : {1'b0, q_x};
  assign mag_y = ovf_y ? MAG_W'(1) << QB : {1'b0, q_y};
  assign sv_x  = $signed({2'b00, mag_x});
  assign sv_y  = $signed({2'b00, mag_y});
  assign val_x = (neg_x ? -sv_x : sv_x) + $signed({23'd0, center_x, 16'd0});
  assign val_y = (neg_y ? -sv_y : sv_y) + $signed({23'd0, center_y, 16'd0});

  always_ff @(posedge clk) begin
    if (cmd.proj) begin
      if (sts.behind) begin
        px <= acc[0][ACC_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
        py <= acc[1][ACC_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
        px <= (val_x > I32_MAX) ? 32'sh7FFFFFFF :
              (val_x < I32_MIN) ? 32'sh80000000 : 32'(val_x);
        py <= (val_y > I32_MAX) ? 32'sh7FFFFFFF :
              (val_y < I32_MIN) ? 32'sh80000000 : 32'(val_y);
      end
    end
  end

  // Squared error
  logic signed [32:0] ex, ey;
  logic [51:0]        sq_x, sq_y;
  logic               in_rng, behind_q;

  assign ex = 33'(ix) - 33'(px);
  assign ey = 33'(iy) - 33'(py);

  always_ff @(posedge clk) begin
    if (cmd.sqr) begin
      sq_x     <= 52'($signed(ex[25:0]) * $signed(ex[25:0]));
      sq_y     <= 52'($signed(ey[25:0]) * $signed(ey[25:0]));
      in_rng   <= (ex < ERR_LIM) && (ex > -ERR_LIM) && (ey < ERR_LIM) && (ey > -ERR_LIM);
      behind_q <= sts.behind;
    end
  end

  // Score and count
  logic             inl;
  logic [CNT_W-1:0] run_cnt, best_cnt, cnt1, floor_best;
  logic             bet;

  assign inl = in_rng && !behind_q &&
               ({1'b0, sq_x} + {1'b0, sq_y} <= {5'd0, error_threshold, 32'd0});
  assign cnt1 = (inl && run_cnt < COUNT_CAP) ? run_cnt + 1'b1 : run_cnt;
  assign floor_best = (best_cnt > MIN_CONS) ? best_cnt : MIN_CONS;
  assign bet = last_q && (cnt1 > floor_best);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt  <= '0;
      best_cnt <= '0;
    end else if (cmd.take && kind == rics_pkg::KIND_BEGIN) begin
      run_cnt  <= '0;
      best_cnt <= '0;
    end else if (cmd.score) begin
      run_cnt <= last_q ? '0 : cnt1;
      if (bet) best_cnt <= cnt1;
    end
  end

  // Result register
  assign sts.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.score) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.score) begin
      proj_x          <= px;
      proj_y          <= py;
      inlier          <= inl;
      good_count      <= cnt1;
      hypothesis_done <= last_q;
      better          <= bet;
    end
  end

endmodule

// ----- design/rics_checker.sv -----
// Port-level checks for the reprojection inlier scoring core, with its bind.
module rics_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic signed [31:0]         proj_x,
  input logic                       hypothesis_done,
  input logic                       better,
  input logic                       inlier,
  input logic [rics_pkg::CNT_W-1:0] good_count
);

  // A stalled transaction holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(proj_x))
    else $error("stalled result changed");

  // Better only on the last point
  a_better_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && better |-> hypothesis_done)
    else $error("better without hypothesis end");

  // A better hypothesis has a nonzero count
  a_better_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && better |-> good_count != '0)
    else $error("better with zero count");

  // An inlier has been counted
  a_inl_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && inlier |-> good_count != '0)
    else $error("inlier with zero count");

  // No result right after reset
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind reprojection_inlier_scoring_core rics_checker u_rics_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .proj_x          (proj_x),
  .hypothesis_done (hypothesis_done),
  .better          (better),
  .inlier          (inlier),
  .good_count      (good_count)
);
